[src/ptpdrs_pkg.sv]
package ptpdrs_pkg;

    localparam int TABLE_ENTRIES = 8;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MSG_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEANUP_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SESSION_TIMEOUT = 2'd2;

    localparam logic [15:0] MSG_INTERVAL_RST = 16'd1000;
    localparam logic [15:0] CLEANUP_INTERVAL_RST = 16'd10000;
    localparam logic [31:0] SESSION_TIMEOUT_RST = 32'd30000;

    localparam logic [3:0] MSG_KIND_REQ = 4'h1;

    localparam logic FUNC_MESSAGE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef struct packed {
        logic        func;
        logic [3:0]  msg_kind;
        logic [63:0] requester_clock_id;
        logic [15:0] requester_port_number;
        logic [31:0] source_ip;
        logic [15:0] request_sequence;
        logic [63:0] receive_time_ns;
        logic [31:0] now_ms;
    } in_t;

    typedef struct packed {
        logic        response_due;
        logic        request_dropped;
        logic [2:0]  entry_slot;
        logic [31:0] response_ip;
        logic [15:0] response_sequence;
        logic [63:0] response_clock_id;
        logic [15:0] response_port_number;
        logic [63:0] response_time_ns;
        logic        sync_due;
        logic [15:0] sync_number;
        logic [3:0]  active_sessions;
    } out_t;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

[src/ptpdrs_ctrl.sv]
module ptpdrs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output ptpdrs_pkg::cmd_t  cmd
);

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_EXEC = 1'b1;

    logic [0:0] state_reg;
    logic [0:0] state_next;
    logic       done_reg;
    logic       done_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        done_next = cmd.exec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
        end
    end

    assign busy = (state_reg == ST_EXEC);
    assign done = done_reg;

endmodule

[src/ptpdrs_dp.sv]
module ptpdrs_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ptpdrs_pkg::cmd_t                      cmd,
    input  ptpdrs_pkg::in_t                       item,
    input  logic                                  cfg_we,
    input  logic [ptpdrs_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [ptpdrs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output ptpdrs_pkg::out_t                      result
);

    localparam int N = ptpdrs_pkg::TABLE_ENTRIES;
    localparam int IW = ptpdrs_pkg::IDX_W;
    localparam int CW = ptpdrs_pkg::CNT_W;

    ptpdrs_pkg::in_t  item_reg;
    ptpdrs_pkg::out_t result_reg;
    ptpdrs_pkg::out_t result_next;

    logic [15:0] msg_interval_reg;
    logic [15:0] cleanup_interval_reg;
    logic [31:0] session_timeout_reg;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;
    logic [63:0]  clock_id_reg [N];
    logic [15:0]  port_number_reg [N];
    logic [31:0]  ip_reg [N];
    logic [31:0]  last_contact_reg [N];

    logic [31:0] last_sync_reg;
    logic [31:0] last_sync_next;
    logic [31:0] last_sweep_reg;
    logic [31:0] last_sweep_next;
    logic [15:0] sync_num_reg;
    logic [15:0] sync_num_next;

    logic          is_req_msg;
    logic          match_found;
    logic [IW-1:0] match_idx;
    logic          free_found;
    logic [IW-1:0] free_idx;
    logic          slot_ok;
    logic          claim;
    logic [IW-1:0] slot_idx;
    logic [31:0]   sync_elapsed;
    logic [31:0]   sweep_elapsed;
    logic          sync_fire;
    logic          sweep_fire;
    logic [N-1:0]  stale;
    logic [CW-1:0] valid_count;

    always_comb
    begin
        match_found = 1'b0;
        match_idx = '0;
        free_found = 1'b0;
        free_idx = '0;
        for (int i = 0; i < N; i++)
        begin
            if (valid_reg[i])
            begin
                if (!match_found && clock_id_reg[i] == item_reg.requester_clock_id
                    && port_number_reg[i] == item_reg.requester_port_number)
                begin
                    match_found = 1'b1;
                    match_idx = IW'(i);
                end
            end
            else if (!free_found)
            begin
                free_found = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    assign is_req_msg = (item_reg.func == ptpdrs_pkg::FUNC_MESSAGE)
                        && (item_reg.msg_kind == ptpdrs_pkg::MSG_KIND_REQ);
    assign slot_ok = match_found || free_found;
    assign claim = is_req_msg && !match_found && free_found;
    assign slot_idx = match_found ? match_idx : free_idx;

    assign sync_elapsed = item_reg.now_ms - last_sync_reg;
    assign sweep_elapsed = item_reg.now_ms - last_sweep_reg;
    assign sync_fire = (item_reg.func == ptpdrs_pkg::FUNC_TICK)
                       && (sync_elapsed >= {16'd0, msg_interval_reg});
    assign sweep_fire = (item_reg.func == ptpdrs_pkg::FUNC_TICK)
                        && (sweep_elapsed >= {16'd0, cleanup_interval_reg});

    // idle time per entry, all compared at once
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            stale[i] = (item_reg.now_ms - last_contact_reg[i]) > session_timeout_reg;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (claim)
        begin
            valid_next[slot_idx] = 1'b1;
        end
        if (sweep_fire)
        begin
            valid_next = valid_reg & ~stale;
        end
    end

    always_comb
    begin
        valid_count = '0;
        for (int i = 0; i < N; i++)
        begin
            valid_count = valid_count + CW'(valid_next[i]);
        end
    end

    assign last_sync_next = sync_fire ? item_reg.now_ms : last_sync_reg;
    assign last_sweep_next = sweep_fire ? item_reg.now_ms : last_sweep_reg;
    assign sync_num_next = sync_fire ? (sync_num_reg + 16'd1) : sync_num_reg;

    always_comb
    begin
        result_next = '0;
        if (is_req_msg)
        begin
            if (slot_ok)
            begin
                result_next.response_due = 1'b1;
                result_next.entry_slot = 3'(slot_idx);
                // a known requester keeps the address stored at claim time
                result_next.response_ip = match_found ? ip_reg[slot_idx] : item_reg.source_ip;
                result_next.response_sequence = item_reg.request_sequence;
                result_next.response_clock_id = item_reg.requester_clock_id;
                result_next.response_port_number = item_reg.requester_port_number;
                result_next.response_time_ns = item_reg.receive_time_ns;
            end
            else
            begin
                result_next.request_dropped = 1'b1;
            end
        end
        if (sync_fire)
        begin
            result_next.sync_due = 1'b1;
            result_next.sync_number = sync_num_reg;
        end
        result_next.active_sessions = 4'(valid_count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_interval_reg <= ptpdrs_pkg::MSG_INTERVAL_RST;
            cleanup_interval_reg <= ptpdrs_pkg::CLEANUP_INTERVAL_RST;
            session_timeout_reg <= ptpdrs_pkg::SESSION_TIMEOUT_RST;
            valid_reg <= '0;
            last_sync_reg <= '0;
            last_sweep_reg <= '0;
            sync_num_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    ptpdrs_pkg::CFG_MSG_INTERVAL:
                        msg_interval_reg <= cfg_wdata[15:0];
                    ptpdrs_pkg::CFG_CLEANUP_INTERVAL:
                        cleanup_interval_reg <= cfg_wdata[15:0];
                    ptpdrs_pkg::CFG_SESSION_TIMEOUT:
                        session_timeout_reg <= cfg_wdata[31:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.exec)
            begin
                valid_reg <= valid_next;
                last_sync_reg <= last_sync_next;
                last_sweep_reg <= last_sweep_next;
                sync_num_reg <= sync_num_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.exec)
        begin
            result_reg <= result_next;
            if (is_req_msg && slot_ok)
            begin
                last_contact_reg[slot_idx] <= item_reg.now_ms;
            end
            if (claim)
            begin
                clock_id_reg[slot_idx] <= item_reg.requester_clock_id;
                port_number_reg[slot_idx] <= item_reg.requester_port_number;
                ip_reg[slot_idx] <= item_reg.source_ip;
            end
        end
    end

    assign result = result_reg;

endmodule

[src/ptp_delay_request_session_table_core.sv]
// The accepting edge loads the request and enters the execute state, from which the
// done strobe is registered. A request is taken only in idle; the single execute state
// does the eight-way identity match, the table update and the result register write.
// done is high for exactly one cycle; busy drops in that cycle, so the next
// request is taken while the result is shown. Results cannot be stalled.
// Reset clears the valid bits, sync/sweep timestamps, sync sequence; config to defaults.
module ptp_delay_request_session_table_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  ptpdrs_pkg::in_t                    item,
    output logic                               busy,
    output logic                               done,
    output ptpdrs_pkg::out_t                   result,
    input  logic                               cfg_we,
    input  logic [ptpdrs_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [ptpdrs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    ptpdrs_pkg::cmd_t cmd;

    ptpdrs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    ptpdrs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .result    (result)
    );

endmodule

[src/ptpdrs_checker.sv]
module ptpdrs_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input ptpdrs_pkg::out_t  result
);

    // an accepted request must be followed by the done strobe
    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result strobe missing after accepted request");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("busy not raised after accepted request");

    a_done_ready: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy while result shown");

    a_resp_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.response_due && result.request_dropped))
        else $error("response and drop both flagged");

    a_resp_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.response_due) |-> (result.active_sessions != 4'd0))
        else $error("response with no active session");

endmodule

bind ptp_delay_request_session_table_core ptpdrs_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
